// ===== sv/ssi_pkg.sv =====
// ssi_pkg: shared widths, status codes and the cell control struct
// for the sorted set insert block; no dependencies
package ssi_pkg;

    localparam int SSI_VALUE_W   = 31;
    localparam int SSI_FIELD_W   = 9;
    localparam int SSI_DEPTH_DEF = 256;

    localparam logic [1:0] ST_INSERTED = 2'd0;
    localparam logic [1:0] ST_PRESENT  = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_CLEARED  = 2'd3;

    typedef struct packed {
        logic                   cmp_en;
        logic                   shift_en;
        logic [SSI_VALUE_W-1:0] value;
    } t_cell_ctl;

endpackage

// ===== sv/ssi_in_if.sv =====
// ssi_in_if: request channel (action, value) with valid/ready
// depends on ssi_pkg
interface ssi_in_if import ssi_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic                   action;
    logic [SSI_VALUE_W-1:0] value;

    modport source (output valid, output action, output value, input ready);
    modport sink   (input valid, input action, input value, output ready);
endinterface

// ===== sv/ssi_out_if.sv =====
// ssi_out_if: result channel (status, position, count) with valid/ready
// depends on ssi_pkg
interface ssi_out_if import ssi_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [1:0]             status;
    logic [SSI_FIELD_W-1:0] position;
    logic [SSI_FIELD_W-1:0] count;

    modport source (output valid, output status, output position, output count, input ready);
    modport sink   (input valid, input status, input position, input count, output ready);
endinterface

// ===== sv/ssi_cell.sv =====
// ssi_cell: one compare-and-shift cell holding one sorted entry
// depends on ssi_pkg
module ssi_cell import ssi_pkg::*; #(
    parameter int IDX = 0,
    parameter int CW  = 9
) (
    input  logic                   i_clk,
    input  t_cell_ctl              i_ctl,
    input  logic [SSI_VALUE_W-1:0] i_prev_entry,
    input  logic                   i_prev_lt,
    input  logic [CW-1:0]          i_count,
    output logic [SSI_VALUE_W-1:0] o_entry,
    output logic                   o_lt,
    output logic                   o_eq
);

    logic [SSI_VALUE_W-1:0] r_entry;
    logic                   r_lt;
    logic                   r_eq;
    logic                   w_occ;

    assign w_occ = CW'(IDX) < i_count;

    always_ff @(posedge i_clk) begin
        if (i_ctl.cmp_en) begin
            r_lt <= w_occ && (r_entry < i_ctl.value);
            r_eq <= w_occ && (r_entry == i_ctl.value);
        end
        if (i_ctl.shift_en && !r_lt) begin
            r_entry <= i_prev_lt ? i_ctl.value : i_prev_entry;
        end
    end

    assign o_entry = r_entry;
    assign o_lt    = r_lt;
    assign o_eq    = r_eq;

endmodule

// ===== sv/ssi_encode.sv =====
// ssi_encode: one-hot to binary encoder for the insert boundary
// no dependencies
module ssi_encode #(
    parameter int N = 257,
    parameter int W = 9
) (
    input  logic [N-1:0] i_onehot,
    output logic [W-1:0] o_index
);

    always_comb begin
        o_index = '0;
        for (int i = 0; i < N; i++) begin
            if (i_onehot[i]) begin
                o_index = o_index | W'(i);
            end
        end
    end

endmodule

// ===== sv/sorted_set_insert_core.sv =====
// sorted_set_insert_core: top level of the sorted set insert block
// depends on ssi_pkg, ssi_in_if, ssi_out_if, ssi_cell, ssi_encode
//
// Holds a strictly increasing set of up to SET_DEPTH 31-bit identifiers in a
// row of compare-and-shift cells. Request beats on i_in carry action (0 insert,
// 1 clear) and value. Each request yields exactly one result beat on o_out with
// status (inserted, present, full, cleared), position and count after the item.
// After a request beat is accepted, every cell compares its entry against the
// value in the compare state; in the update state that follows, the boundary
// is encoded, the cells shift and the output register loads.
// The block takes the next request beat only in its idle state, after the
// compare then update sequence through the shared cell row has finished.
// A new request is taken while the previous result still waits in the output
// register; if the receiver stalls, the block holds in its update step until
// the output register frees, with cell flags held stable.
// Reset (synchronous, active low) empties the set and drops any pending
// result; cell contents are not cleared, only the count.
module sorted_set_insert_core import ssi_pkg::*; #(
    parameter int SET_DEPTH = SSI_DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ssi_in_if.sink    i_in,
    ssi_out_if.source o_out
);

    localparam int CW = $clog2(SET_DEPTH + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CMP  = 2'd1;
    localparam logic [1:0] S_UPD  = 2'd2;

    logic [1:0]             r_state;
    logic [1:0]             n_state;
    logic [CW-1:0]          r_count;
    logic                   r_action;
    logic [SSI_VALUE_W-1:0] r_value;
    logic                   r_ovalid;
    logic [1:0]             r_status;
    logic [SSI_FIELD_W-1:0] r_pos;
    logic [SSI_FIELD_W-1:0] r_ocount;

    t_cell_ctl              w_ctl;
    logic [SSI_VALUE_W-1:0] w_entry [SET_DEPTH];
    logic [SET_DEPTH-1:0]   w_lt;
    logic [SET_DEPTH-1:0]   w_eq;
    logic [SET_DEPTH:0]     w_onehot;
    logic [CW-1:0]          w_pos;
    logic [31:0]            w_pos32;
    logic [31:0]            w_cnt32;
    logic [CW-1:0]          w_next_count;
    logic                   w_found;
    logic                   w_full;
    logic                   w_ins;
    logic                   w_load;
    logic                   w_accept;

    assign i_in.ready = i_rst_n && (r_state == S_IDLE);
    assign w_accept   = i_in.valid && i_in.ready;

    assign w_found = |w_eq;
    assign w_full  = (r_count == CW'(SET_DEPTH));
    assign w_ins   = !r_action && !w_found && !w_full;
    assign w_load  = (r_state == S_UPD) && (!r_ovalid || o_out.ready);

    assign w_ctl.cmp_en   = (r_state == S_CMP);
    assign w_ctl.shift_en = w_load && w_ins;
    assign w_ctl.value    = r_value;

    for (genvar g = 0; g < SET_DEPTH; g++) begin : g_cell
        if (g == 0) begin : g_first
            ssi_cell #(.IDX(g), .CW(CW)) u_cell (
                .i_clk        (i_clk),
                .i_ctl        (w_ctl),
                .i_prev_entry (r_value),
                .i_prev_lt    (1'b1),
                .i_count      (r_count),
                .o_entry      (w_entry[g]),
                .o_lt         (w_lt[g]),
                .o_eq         (w_eq[g])
            );
            assign w_onehot[g] = !w_lt[g];
        end else begin : g_rest
            ssi_cell #(.IDX(g), .CW(CW)) u_cell (
                .i_clk        (i_clk),
                .i_ctl        (w_ctl),
                .i_prev_entry (w_entry[g-1]),
                .i_prev_lt    (w_lt[g-1]),
                .i_count      (r_count),
                .o_entry      (w_entry[g]),
                .o_lt         (w_lt[g]),
                .o_eq         (w_eq[g])
            );
            assign w_onehot[g] = w_lt[g-1] && !w_lt[g];
        end
    end
    assign w_onehot[SET_DEPTH] = w_lt[SET_DEPTH-1];

    ssi_encode #(.N(SET_DEPTH + 1), .W(CW)) u_encode (
        .i_onehot (w_onehot),
        .o_index  (w_pos)
    );

    assign w_next_count = r_action ? '0 : (w_ins ? r_count + CW'(1) : r_count);
    assign w_pos32      = 32'(w_pos);
    assign w_cnt32      = 32'(w_next_count);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) n_state = S_CMP;
            end
            S_CMP: begin
                n_state = S_UPD;
            end
            S_UPD: begin
                if (w_load) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_count  <= w_next_count;
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_action <= i_in.action;
            r_value  <= i_in.value;
        end
        if (w_load) begin
            r_ocount <= w_cnt32[SSI_FIELD_W-1:0];
            priority if (r_action) begin
                r_status <= ST_CLEARED;
                r_pos    <= '0;
            end else if (w_found) begin
                r_status <= ST_PRESENT;
                r_pos    <= w_pos32[SSI_FIELD_W-1:0];
            end else if (w_full) begin
                r_status <= ST_FULL;
                r_pos    <= w_pos32[SSI_FIELD_W-1:0];
            end else begin
                r_status <= ST_INSERTED;
                r_pos    <= w_pos32[SSI_FIELD_W-1:0];
            end
        end
    end

    assign o_out.valid    = r_ovalid;
    assign o_out.status   = r_status;
    assign o_out.position = r_pos;
    assign o_out.count    = r_ocount;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(SET_DEPTH))
        else $error("entry count above depth");

    a_eq_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPD) |-> $onehot0(w_eq))
        else $error("more than one cell matches");

    a_boundary: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPD) |-> $onehot(w_onehot))
        else $error("insert boundary not unique");

    a_ins_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && w_ins) |=> (r_count == $past(r_count) + CW'(1)))
        else $error("insert did not grow the set by one");

endmodule
